FILE: hw/rtl/tst_pkg.sv
// Package with the constants, codes and shared types of the topic subscriber table.
package tst_pkg;

   localparam int TOPICS    = 16;
   localparam int SLOTS     = 8;
   localparam int ID_BITS   = 8;
   localparam int DATA_BITS = 32;

   localparam int MODE_W    = 2;
   localparam int TOPIC_W   = 4;
   localparam int SUBID_W   = 8;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 4;

   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int TIDX_W    = (TOPICS > 1) ? $clog2(TOPICS) : 1;
   localparam int RAM_DEPTH = TOPICS * SLOTS;
   localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   localparam logic [MODE_W-1:0] MODE_SUB   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNSUB = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PUB   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_W-1:0]    wr_addr;
      logic [ID_BITS-1:0]   wr_data;
      logic                 rd_en;
      logic [ADDR_W-1:0]    rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SUBID_W-1:0]   target;
      logic [TOPIC_W-1:0]   topic_out;
      logic [PAYLOAD_W-1:0] data_out;
      logic [COUNT_W-1:0]   count;
      logic                 last;
   } rsp_type;

endpackage

FILE: hw/rtl/tst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/tst_ctrl.sv
// Sequencer that holds the topic counts and walks the subscriber list memory.
module tst_ctrl
   import tst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [TOPIC_W-1:0]   req_topic,
   input  logic [SUBID_W-1:0]   req_subscriber,
   input  logic [PAYLOAD_W-1:0] req_payload,
   output ram_req_type          ram_req,
   input  logic [ID_BITS-1:0]   ram_rd_data,
   input  logic                 out_free,
   output logic                 rsp_load,
   output rsp_type              rsp_next
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_SHIFT = 5'b00100,
      ST_PUB   = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [TOPIC_W-1:0]    topic_ff, topic_in;
   logic [TIDX_W-1:0]     tidx_ff, tidx_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [DATA_BITS-1:0]  data_ff, data_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [CNT_W-1:0]      counts_ff [TOPICS];

   logic                  cnt_we;
   logic [TIDX_W-1:0]     cnt_widx;
   logic [CNT_W-1:0]      cnt_wdata;

   logic                  topic_ok;
   logic [TIDX_W-1:0]     tidx_acc;
   logic [ID_BITS-1:0]    id_acc;
   logic [CNT_W-1:0]      n_acc;
   logic [ADDR_W-1:0]     base_acc;
   logic [CNT_W:0]        nxt;
   logic [CNT_W:0]        nxt2;
   logic                  more;

   always_comb begin
      topic_ok = (32'(req_topic) < TOPICS);
      tidx_acc = TIDX_W'(req_topic);
      id_acc   = ID_BITS'(req_subscriber);
      n_acc    = topic_ok ? counts_ff[tidx_acc] : '0;
      base_acc = ADDR_W'(32'(tidx_acc) * SLOTS);
      nxt      = {1'b0, idx_ff} + 1'b1;
      nxt2     = {1'b0, idx_ff} + 2'd2;
      more     = (nxt < {1'b0, n_ff});
   end

   always_comb begin
      state_in  = state_ff;
      topic_in  = topic_ff;
      tidx_in   = tidx_ff;
      id_in     = id_ff;
      data_in   = data_ff;
      n_in      = n_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      base_in   = base_ff;
      req_ready = 1'b0;
      ram_req   = '0;
      cnt_we    = 1'b0;
      cnt_widx  = tidx_ff;
      cnt_wdata = n_ff - 1'b1;
      rsp_load  = 1'b0;
      rsp_next  = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               topic_in = req_topic;
               tidx_in  = tidx_acc;
               id_in    = id_acc;
               data_in  = DATA_BITS'(req_payload);
               n_in     = n_acc;
               idx_in   = '0;
               base_in  = base_acc;
               case (req_mode)
                  MODE_SUB: begin
                     state_in = ST_RESP;
                     if (!topic_ok || id_acc == '0) begin
                        status_in = STATUS_INVALID;
                     end else if (32'(n_acc) >= SLOTS) begin
                        status_in = STATUS_FULL;
                     end else begin
                        status_in       = STATUS_OK;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = base_acc + ADDR_W'(n_acc);
                        ram_req.wr_data = id_acc;
                        cnt_we          = 1'b1;
                        cnt_widx        = tidx_acc;
                        cnt_wdata       = n_acc + 1'b1;
                        n_in            = n_acc + 1'b1;
                     end
                  end
                  MODE_UNSUB: begin
                     if (!topic_ok || id_acc == '0 || n_acc == '0) begin
                        status_in = STATUS_INVALID;
                        state_in  = ST_RESP;
                     end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = base_acc;
                        state_in        = ST_CHECK;
                     end
                  end
                  MODE_PUB: begin
                     if (topic_ok && n_acc != '0) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = base_acc;
                        state_in        = ST_PUB;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (ram_rd_data == id_ff) begin
               if (more) begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = base_ff + ADDR_W'(nxt);
                  state_in        = ST_SHIFT;
               end else begin
                  cnt_we    = 1'b1;
                  n_in      = n_ff - 1'b1;
                  status_in = STATUS_OK;
                  state_in  = ST_RESP;
               end
            end else if (more) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = base_ff + ADDR_W'(nxt);
               idx_in          = CNT_W'(nxt);
            end else begin
               status_in = STATUS_INVALID;
               state_in  = ST_RESP;
            end
         end
         ST_SHIFT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = base_ff + ADDR_W'(idx_ff);
            ram_req.wr_data = ram_rd_data;
            idx_in          = CNT_W'(nxt);
            if (nxt2 < {1'b0, n_ff}) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = base_ff + ADDR_W'(nxt2);
            end else begin
               cnt_we    = 1'b1;
               n_in      = n_ff - 1'b1;
               status_in = STATUS_OK;
               state_in  = ST_RESP;
            end
         end
         ST_PUB: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_next.status    = STATUS_OK;
               rsp_next.target    = SUBID_W'(ram_rd_data);
               rsp_next.topic_out = topic_ff;
               rsp_next.data_out  = PAYLOAD_W'(data_ff);
               rsp_next.count     = COUNT_W'(n_ff);
               rsp_next.last      = !more;
               if (more) begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = base_ff + ADDR_W'(nxt);
                  idx_in          = CNT_W'(nxt);
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_next.status    = status_ff;
               rsp_next.topic_out = topic_ff;
               rsp_next.count     = COUNT_W'(n_ff);
               rsp_next.last      = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int t = 0; t < TOPICS; t++) begin
            counts_ff[t] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (cnt_we) begin
            counts_ff[cnt_widx] <= cnt_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      topic_ff  <= topic_in;
      tidx_ff   <= tidx_in;
      id_ff     <= id_in;
      data_ff   <= data_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      base_ff   <= base_in;
   end

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
      else $error("Read and write hit the same list entry in one cycle.");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("Result loaded while the output register is still full.");

   a_idx_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK || state_ff == ST_PUB || state_ff == ST_SHIFT)
      |-> (idx_ff < n_ff))
      else $error("List index ran past the topic count.");

   a_shift_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> ram_req.wr_en)
      else $error("Shift step did not move an entry down.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (32'(cnt_wdata) <= SLOTS))
      else $error("Topic count written above the list capacity.");

endmodule

FILE: hw/rtl/topic_subscriber_table_top.sv
// Top level of the topic subscriber table: list memory, sequencer and output register.
//
//  Channel  Direction  Handshake             Fields
//  req_     in         req_valid/req_ready   mode, topic, subscriber, payload
//  rsp_     out        rsp_valid/rsp_ready   status, target, topic_out, data_out, count, last
//
// Subscribe and rejected unsubscribe requests answer from the response state; a publish
// to an empty or invalid topic and an unknown mode give no result. Unsubscribe takes one
// memory read per entry up to the match, then one read-write per later entry, all in the
// single list memory. Publish gives one result per cycle while the output is free.
// Reset clears all topic counts at once, so every list reads as empty after reset.
// A stalled result holds the sequencer in place; nothing is lost or repeated.
module topic_subscriber_table_top
   import tst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [TOPIC_W-1:0]   req_topic,
   input  logic [SUBID_W-1:0]   req_subscriber,
   input  logic [PAYLOAD_W-1:0] req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SUBID_W-1:0]   rsp_target,
   output logic [TOPIC_W-1:0]   rsp_topic_out,
   output logic [PAYLOAD_W-1:0] rsp_data_out,
   output logic [COUNT_W-1:0]   rsp_count,
   output logic                 rsp_last
);

   ram_req_type         ram_req;
   logic [ID_BITS-1:0]  ram_rd_data;
   logic                out_free;
   logic                rsp_load;
   rsp_type             rsp_next;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   tst_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   tst_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_topic      (req_topic),
      .req_subscriber (req_subscriber),
      .req_payload    (req_payload),
      .ram_req        (ram_req),
      .ram_rd_data    (ram_rd_data),
      .out_free       (out_free),
      .rsp_load       (rsp_load),
      .rsp_next       (rsp_next)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_ff.status;
   assign rsp_target    = rsp_ff.target;
   assign rsp_topic_out = rsp_ff.topic_out;
   assign rsp_data_out  = rsp_ff.data_out;
   assign rsp_count     = rsp_ff.count;
   assign rsp_last      = rsp_ff.last;

endmodule

FILE: tb/tb_top.sv
// Testbench for topic_subscriber_table_top: table scoreboard, request and response drivers.
`timescale 1ns / 1ps

import tst_pkg::*;

class subscription_scoreboard;
   logic [SUBID_W-1:0] id_lists [TOPICS][SLOTS];
   int unsigned        list_len [TOPICS];
   rsp_type            pending_results[$];
   int                 errors;

   function new();
      for (int t = 0; t < TOPICS; t++) begin
         list_len[t] = 0;
         for (int s = 0; s < SLOTS; s++) id_lists[t][s] = '0;
      end
      errors = 0;
   endfunction

   function void queue_result(logic [STATUS_W-1:0] status, logic [SUBID_W-1:0] target,
                              logic [TOPIC_W-1:0] topic, logic [PAYLOAD_W-1:0] data,
                              int unsigned count, logic last);
      rsp_type r;
      r.status    = status;
      r.target    = target;
      r.topic_out = topic;
      r.data_out  = data;
      r.count     = count[COUNT_W-1:0];
      r.last      = last;
      pending_results.push_back(r);
   endfunction

   function void note_request(logic [MODE_W-1:0] mode, logic [TOPIC_W-1:0] topic,
                              logic [SUBID_W-1:0] subscriber, logic [PAYLOAD_W-1:0] payload);
      logic                topic_ok;
      logic [ID_BITS-1:0]  id;
      int unsigned         t;
      int unsigned         n;
      int                  hit;
      topic_ok = (int'(topic) < TOPICS);
      id       = subscriber[ID_BITS-1:0];
      t        = topic_ok ? int'(topic) : 0;
      n        = topic_ok ? list_len[t] : 0;
      hit      = -1;
      case (mode)
         MODE_SUB: begin
            if (!topic_ok || id == '0) begin
               queue_result(STATUS_INVALID, '0, topic, '0, n, 1'b1);
            end else if (n >= SLOTS) begin
               queue_result(STATUS_FULL, '0, topic, '0, n, 1'b1);
            end else begin
               id_lists[t][n] = id;
               list_len[t]    = n + 1;
               queue_result(STATUS_OK, '0, topic, '0, n + 1, 1'b1);
            end
         end
         MODE_UNSUB: begin
            if (topic_ok && id != '0) begin
               for (int i = 0; i < n; i++) begin
                  if (hit < 0 && id_lists[t][i] == id) hit = i;
               end
            end
            if (hit < 0) begin
               queue_result(STATUS_INVALID, '0, topic, '0, n, 1'b1);
            end else begin
               for (int j = hit; j + 1 < n; j++) id_lists[t][j] = id_lists[t][j+1];
               id_lists[t][n-1] = '0;
               list_len[t]      = n - 1;
               queue_result(STATUS_OK, '0, topic, '0, n - 1, 1'b1);
            end
         end
         MODE_PUB: begin
            if (topic_ok) begin
               for (int i = 0; i < n; i++) begin
                  queue_result(STATUS_OK, id_lists[t][i], topic, payload, n, i + 1 == n);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected transfer, expected none, actual %p", $time, got);
         errors++;
      end else begin
         want = pending_results.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("target", 32'(want.target), 32'(got.target));
         compare_field("topic_out", 32'(want.topic_out), 32'(got.topic_out));
         compare_field("data_out", 32'(want.data_out), 32'(got.data_out));
         compare_field("count", 32'(want.count), 32'(got.count));
         compare_field("last", 32'(want.last), 32'(got.last));
      end
   endfunction
endclass

module tb_top;

   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
   localparam int RANDOM_ITEMS  = 72;
   localparam int HOLD_AFTER    = 40;
   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_CYCLES  = 30;
   localparam int CYCLE_LIMIT   = 100000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [MODE_W-1:0]    req_mode;
   logic [TOPIC_W-1:0]   req_topic;
   logic [SUBID_W-1:0]   req_subscriber;
   logic [PAYLOAD_W-1:0] req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SUBID_W-1:0]   rsp_target;
   logic [TOPIC_W-1:0]   rsp_topic_out;
   logic [PAYLOAD_W-1:0] rsp_data_out;
   logic [COUNT_W-1:0]   rsp_count;
   logic                 rsp_last;

   subscription_scoreboard table_model;
   int                     quiet_left [2];
   int                     cycle_count;
   int                     responses_seen;

   topic_subscriber_table_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_topic      (req_topic),
      .req_subscriber (req_subscriber),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_target     (rsp_target),
      .rsp_topic_out  (rsp_topic_out),
      .rsp_data_out   (rsp_data_out),
      .rsp_count      (rsp_count),
      .rsp_last       (rsp_last)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("topic_subscriber_table_top test failed");
         $finish;
      end
   end

   // Side 0 is the request sender, side 1 the response receiver.
   function automatic int draw_gap(input int side);
      if (quiet_left[side] > 0) begin
         quiet_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 11) == 0) quiet_left[side] = $urandom_range(8, 20);
      return $urandom_range(0, 6);
   endfunction

   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [TOPIC_W-1:0] topic,
                               input logic [SUBID_W-1:0] subscriber,
                               input logic [PAYLOAD_W-1:0] payload);
      int gap;
      gap = draw_gap(0);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_topic      <= topic;
      req_subscriber <= subscriber;
      req_payload    <= payload;
      do @(posedge clock); while (!req_ready);
      table_model.note_request(mode, topic, subscriber, payload);
   endtask

   // The receiver holds off once for a long stretch so that the block fills and stalls.
   initial begin
      int      gap;
      bit      held;
      rsp_type got;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap(1);
         if (!held && responses_seen >= HOLD_AFTER) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.status    = rsp_status;
         got.target    = rsp_target;
         got.topic_out = rsp_topic_out;
         got.data_out  = rsp_data_out;
         got.count     = rsp_count;
         got.last      = rsp_last;
         table_model.check_response(got);
         responses_seen++;
         @(negedge clock);
      end
   end

   initial begin
      int                   sent;
      int                   pick;
      logic [MODE_W-1:0]    mode;
      logic [TOPIC_W-1:0]   topic;
      logic [SUBID_W-1:0]   subscriber;
      table_model    = new();
      quiet_left[0]  = 0;
      quiet_left[1]  = 0;
      cycle_count    = 0;
      responses_seen = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_SUB;
      req_topic      = '0;
      req_subscriber = '0;
      req_payload    = '0;
      rsp_ready      = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(MODE_SUB, 4'd0, 8'd0, 32'h0);
      send_request(MODE_SUB, 4'd15, 8'd255, 32'hFFFF_FFFF);
      send_request(MODE_SUB, 4'd0, 8'd1, 32'h0);
      send_request(MODE_SUB, 4'd3, 8'd5, 32'h0);
      send_request(MODE_SUB, 4'd3, 8'd9, 32'h0);
      send_request(MODE_SUB, 4'd3, 8'd5, 32'h0);
      send_request(MODE_SUB, 4'd3, 8'd200, 32'h0);
      send_request(MODE_SUB, 4'd3, 8'd7, 32'h0);
      send_request(MODE_SUB, 4'd3, 8'd128, 32'h0);
      send_request(MODE_SUB, 4'd3, 8'd64, 32'h0);
      send_request(MODE_SUB, 4'd3, 8'd3, 32'h0);
      send_request(MODE_SUB, 4'd3, 8'd77, 32'h0);
      send_request(MODE_PUB, 4'd3, 8'd0, 32'hFFFF_FFFF);
      send_request(MODE_UNSUB, 4'd3, 8'd5, 32'h0);
      send_request(MODE_UNSUB, 4'd3, 8'd99, 32'h0);
      send_request(MODE_UNSUB, 4'd3, 8'd0, 32'h0);
      send_request(MODE_PUB, 4'd3, 8'd0, 32'h0);
      send_request(MODE_PUB, 4'd7, 8'd0, 32'h1234_5678);
      send_request(MODE_NONE, 4'd3, 8'd9, 32'hDEAD_BEEF);
      send_request(MODE_UNSUB, 4'd15, 8'd255, 32'h0);
      send_request(MODE_PUB, 4'd15, 8'd0, 32'h5A5A_5A5A);
      send_request(MODE_PUB, 4'd0, 8'd0, 32'hA5A5_A5A5);
      send_request(MODE_UNSUB, 4'd3, 8'd3, 32'h0);
      send_request(MODE_PUB, 4'd3, 8'd0, 32'h8000_0001);

      // Mostly a few busy topics and a small id pool, so lists fill and removals hit.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) mode = MODE_SUB;
         else if (pick < 68) mode = MODE_UNSUB;
         else if (pick < 95) mode = MODE_PUB;
         else mode = MODE_NONE;
         topic      = ($urandom_range(0, 9) == 0) ? TOPIC_W'($urandom_range(0, 15))
                                                  : TOPIC_W'($urandom_range(0, 3));
         subscriber = ($urandom_range(0, 7) == 0) ? SUBID_W'($urandom_range(0, 255))
                                                  : SUBID_W'($urandom_range(1, 10));
         send_request(mode, topic, subscriber, $urandom);
         if (mode != MODE_NONE) sent++;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (table_model.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_model.errors == 0) begin
         $display("topic_subscriber_table_top test passed");
      end else begin
         $display("topic_subscriber_table_top test failed");
      end
      $finish;
   end

endmodule

FILE: topic_subscriber_table_top.f
hw/rtl/tst_pkg.sv
hw/rtl/tst_ram.sv
hw/rtl/tst_ctrl.sv
hw/rtl/topic_subscriber_table_top.sv
tb/tb_top.sv
